// ===== rtl/core/tcmv_pkg.sv =====
// Shared types and constants for the 8-PSK trellis decoder.
`default_nettype none
package tcmv_pkg;
    localparam int NSTATES = 4;
    // survivor entry per state: {uncoded bit, predecessor[1:0]}
    typedef logic [2:0] t_surv;
    typedef logic [11:0] t_column;

    // coordinate codes: 2 = +1.0, 1 = +0.7, 0 = 0, -1, -2
    function automatic logic signed [2:0] pt_i(input logic [2:0] k);
        logic signed [2:0] r;
        case (k)
            3'd0: r = 3'sd1;
            3'd1: r = 3'sd2;
            3'd2: r = 3'sd1;
            3'd3: r = 3'sd0;
            3'd4: r = -3'sd1;
            3'd5: r = -3'sd2;
            3'd6: r = -3'sd1;
            default: r = 3'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [2:0] pt_q(input logic [2:0] k);
        logic signed [2:0] r;
        case (k)
            3'd0: r = -3'sd1;
            3'd1: r = 3'sd0;
            3'd2: r = 3'sd1;
            3'd3: r = 3'sd2;
            3'd4: r = 3'sd1;
            3'd5: r = 3'sd0;
            3'd6: r = -3'sd1;
            default: r = -3'sd2;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] pred_lo(input logic [1:0] s);
        logic [1:0] r;
        case (s)
            2'd0: r = 2'd0;
            2'd1: r = 2'd2;
            2'd2: r = 2'd1;
            default: r = 2'd3;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] pred_hi(input logic [1:0] s);
        logic [1:0] r;
        case (s)
            2'd0: r = 2'd1;
            2'd1: r = 2'd3;
            2'd2: r = 2'd0;
            default: r = 2'd2;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/tcmv_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
`default_nettype none
module tcmv_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 9
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/tcmv_bmu.sv =====
// Branch metric for one constellation point, squared distance over I and Q.
`default_nettype none
module tcmv_bmu #(
    parameter int SAMPLE_WIDTH = 12,
    parameter int METRIC_WIDTH = 16
) (
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_x,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_y,
    input  wire logic [2:0]                     i_point,
    output logic      [METRIC_WIDTH-1:0]        o_metric
);
    import tcmv_pkg::*;
    localparam int DW = SAMPLE_WIDTH + 2;
    localparam int SW = 2 * DW + 1;
    localparam logic signed [DW-1:0] ONE = DW'(1) <<< (SAMPLE_WIDTH - 2);
    localparam logic signed [DW-1:0] P7 =
        DW'(((longint'(1) << (SAMPLE_WIDTH - 2)) * 7 + 5) / 10);

    function automatic logic signed [DW-1:0] coord(input logic signed [2:0] c);
        logic signed [DW-1:0] r;
        case (c)
            3'sd2: r = ONE;
            3'sd1: r = P7;
            -3'sd1: r = -P7;
            -3'sd2: r = -ONE;
            default: r = '0;
        endcase
        return r;
    endfunction

    logic signed [DW-1:0] dx, dy;
    logic signed [2*DW-1:0] px, py;
    logic [SW-1:0] sq, sh;
    always_comb begin
        dx = DW'(i_x) - coord(pt_i(i_point));
        dy = DW'(i_y) - coord(pt_q(i_point));
        px = dx * dx;
        py = dy * dy;
        sq = SW'(unsigned'(px)) + SW'(unsigned'(py));
        sh = sq >> (SAMPLE_WIDTH - 2);
        if (sh > SW'({METRIC_WIDTH{1'b1}})) o_metric = '1;
        else o_metric = sh[METRIC_WIDTH-1:0];
    end
endmodule
`default_nettype wire

// ===== rtl/core/tcm_8psk_viterbi_decoder_unit.sv =====
// Top level of the 4-state 8-PSK trellis decoder with sequential traceback.
//
//  channel | dir | beat contents          | handshake
//  in      | in  | i_sample_i, i_sample_q | i_in_valid / o_in_ready
//  out     | out | o_decoded_symbol       | o_out_valid / i_out_ready
//
// Sequence: S_IDLE takes the beat, S_ACS forms branch metric and ACS over every
// point (one point per cycle), S_NORM normalizes and writes the column and,
// while the ring fills, returns to S_IDLE. Once full, S_TB traces back through
// the registered RAM port and S_LAST loads the result.
// Reset: synchronous; path metrics state 0 zero, others all ones; ring unset.
// Stalls: a result waits in the output register; hold in S_LAST only
// when the next result is ready before the previous beat has left.
`default_nettype none
module tcm_8psk_viterbi_decoder_unit #(
    parameter int TRACEBACK_DEPTH = 9,
    parameter int METRIC_WIDTH = 16,
    parameter int SAMPLE_WIDTH = 12
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample_i,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample_q,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [1:0]                          o_decoded_symbol
);
    import tcmv_pkg::*;
    localparam int AW = $clog2(TRACEBACK_DEPTH);
    localparam int CW = $clog2(TRACEBACK_DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(TRACEBACK_DEPTH - 1);
    localparam int TBW = $clog2(TRACEBACK_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ACS  = 3'd1;
    localparam logic [2:0] S_NORM = 3'd2;
    localparam logic [2:0] S_TB   = 3'd3;
    localparam logic [2:0] S_LAST = 3'd4;

    logic [2:0] r_state, n_state;
    logic signed [SAMPLE_WIDTH-1:0] r_x, r_y;
    logic [METRIC_WIDTH-1:0] r_pm [NSTATES];
    logic [METRIC_WIDTH:0]   r_best [NSTATES];
    t_surv   r_surv [NSTATES];
    logic [2:0] r_k;           // point index within the ACS pass
    logic [AW-1:0] r_wp, r_col;
    logic [CW-1:0] r_fill;
    logic [TBW:0] r_n;
    logic [1:0] r_ws, r_beststate;
    logic r_out_valid;
    logic [1:0] r_sym;

    logic [METRIC_WIDTH-1:0] bm;
    tcmv_bmu #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .METRIC_WIDTH(METRIC_WIDTH)) u_bmu (
        .i_x(r_x), .i_y(r_y), .i_point(r_k), .o_metric(bm)
    );

    // point k feeds states with a = k&1: states {k[0], k[0]+2}; j = k>>1
    logic [1:0] sa, sb;
    logic [1:0] j;
    logic [1:0] pa, pb;
    logic [METRIC_WIDTH:0] suma, sumb;
    always_comb begin
        sa = {1'b0, r_k[0]};
        sb = {1'b1, r_k[0]};
        j  = r_k[2:1];
        pa = j[0] ? pred_hi(sa) : pred_lo(sa);
        pb = j[0] ? pred_hi(sb) : pred_lo(sb);
        suma = {1'b0, r_pm[pa]} + {1'b0, bm};
        sumb = {1'b0, r_pm[pb]} + {1'b0, bm};
    end

    // saturated new metrics and minimum
    logic [METRIC_WIDTH-1:0] nm [NSTATES];
    logic [METRIC_WIDTH-1:0] lo;
    logic [1:0] lo_s;
    always_comb begin
        for (int s = 0; s < NSTATES; s++)
            nm[s] = r_best[s][METRIC_WIDTH] ? '1 : r_best[s][METRIC_WIDTH-1:0];
        lo = nm[0];
        lo_s = 2'd0;
        for (int s = 1; s < NSTATES; s++)
            if (nm[s] < lo) begin
                lo = nm[s];
                lo_s = 2'(s);
            end
    end

    logic ram_we;
    t_column wdata, rdata;
    logic [AW-1:0] raddr;
    assign ram_we = (r_state == S_NORM);
    assign wdata = {r_surv[3], r_surv[2], r_surv[1], r_surv[0]};
    assign raddr = r_col;
    tcmv_ram #(.WIDTH(12), .DEPTH(TRACEBACK_DEPTH)) u_ring (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(r_wp), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    t_surv rd_entry;
    assign rd_entry = t_surv'(rdata >> (3 * r_ws));

    logic out_load;
    assign out_load = (r_state == S_LAST) && (!r_out_valid || i_out_ready);

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_decoded_symbol = r_sym;

    logic [AW-1:0] wp_next;
    assign wp_next = (r_wp == LAST) ? '0 : r_wp + 1'b1;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid && o_in_ready) n_state = S_ACS;
            S_ACS:  if (r_k == 3'd7) n_state = S_NORM;
            S_NORM: n_state = (r_fill < CW'(TRACEBACK_DEPTH - 1)) ? S_IDLE : S_TB;
            S_TB:   if (r_n == (TBW+1)'(TRACEBACK_DEPTH)) n_state = S_LAST;
            S_LAST: if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wp <= '0;
            r_fill <= '0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < NSTATES; s++) r_pm[s] <= (s == 0) ? '0 : '1;
        end else begin
            r_state <= n_state;
            // load a new result, or drop the one just taken
            if (out_load) r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_in_valid && o_in_ready) begin
                    r_x <= i_sample_i;
                    r_y <= i_sample_q;
                    r_k <= 3'd0;
                end
                S_ACS: begin
                    // keep the first minimum in scan order
                    if (j == 2'd0 || suma < r_best[sa]) begin
                        r_best[sa] <= suma;
                        r_surv[sa] <= {j[1], pa};
                    end
                    if (j == 2'd0 || sumb < r_best[sb]) begin
                        r_best[sb] <= sumb;
                        r_surv[sb] <= {j[1], pb};
                    end
                    r_k <= r_k + 3'd1;
                end
                S_NORM: begin
                    for (int s = 0; s < NSTATES; s++) r_pm[s] <= nm[s] - lo;
                    r_beststate <= lo_s;
                    r_ws <= lo_s;
                    r_col <= r_wp;
                    r_n <= '0;
                    r_wp <= wp_next;
                    if (r_fill < CW'(TRACEBACK_DEPTH - 1)) r_fill <= r_fill + 1'b1;
                end
                S_TB: begin
                    // column reads run one step ahead of the state walk
                    r_n <= r_n + 1'b1;
                    if (r_n != '0 && r_n != (TBW+1)'(TRACEBACK_DEPTH))
                        r_ws <= rd_entry[1:0];
                    if (r_n < (TBW+1)'(TRACEBACK_DEPTH - 1))
                        r_col <= (r_col == '0) ? LAST : r_col - 1'b1;
                end
                S_LAST: begin
                    if (out_load) r_sym <= {rd_entry[2], r_ws[1]};
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready) else $error("ready while busy");
    a_out_from_tb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_LAST) else $error("stray result");
    a_norm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_state) == S_NORM && $past(i_rst_n) |-> r_pm[r_beststate] == '0)
        else $error("metric not normalized");
`endif
endmodule
`default_nettype wire

// ===== tb/tcm_8psk_viterbi_decoder_unit_tb.sv =====
// Self-checking testbench for the 4-state 8-PSK trellis decoder.
`default_nettype none
module tcm_8psk_viterbi_decoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 9;
    localparam int MW = 16;
    localparam int SW = 12;
    localparam longint MMAX = (64'd1 << MW) - 1;
    localparam longint ONE = 64'd1 << (SW - 2);
    localparam longint P7 = (ONE * 7 + 5) / 10;
    localparam int N_RANDOM = 1330;

    typedef struct packed {
        logic [SW-1:0] si;
        logic [SW-1:0] sq;
    } sample_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_out_ready = 1'b0;
    logic signed [SW-1:0] i_sample_i = '0;
    logic signed [SW-1:0] i_sample_q = '0;
    logic o_in_ready;
    logic o_out_valid;
    logic [1:0] o_decoded_symbol;

    tcm_8psk_viterbi_decoder_unit #(
        .TRACEBACK_DEPTH(DEPTH),
        .METRIC_WIDTH(MW),
        .SAMPLE_WIDTH(SW)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_sample_i(i_sample_i),
        .i_sample_q(i_sample_q),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_decoded_symbol(o_decoded_symbol)
    );

    always #5 i_clk = ~i_clk;

    // Decoder state mirrored on the bench side.
    longint path_metric[4];
    logic [1:0] surv_pred[DEPTH][4];
    logic surv_unc[DEPTH][4];
    int wr_col;
    int fill;

    sample_t pending_samples[$];
    logic [1:0] expected_symbols[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // Coordinate code to fixed point: +-2 is +-1.0, +-1 is +-0.7.
    function automatic longint coord(int c);
        longint mag;
        mag = (c == 2 || c == -2) ? ONE : (c == 0 ? 0 : P7);
        return c < 0 ? -mag : mag;
    endfunction

    function automatic longint branch_cost(longint x, longint y, int k);
        longint dx, dy, sq;
        dx = x - coord(tcmv_pkg::pt_i(k[2:0]));
        dy = y - coord(tcmv_pkg::pt_q(k[2:0]));
        sq = (dx * dx + dy * dy) >>> (SW - 2);
        return sq > MMAX ? MMAX : sq;
    endfunction

    task automatic decoder_reset();
        for (int s = 0; s < 4; s++) path_metric[s] = (s == 0) ? 0 : MMAX;
        wr_col = 0;
        fill = 0;
    endtask

    // Advance the trellis one sample; queue a symbol once the ring is full.
    task automatic decode_sample(sample_t smp);
        longint x, y, lo, sum, best_sum;
        longint bm[8];
        longint nm[4];
        int a, p, bp, bu, best, st, col;
        x = longint'($signed(smp.si));
        y = longint'($signed(smp.sq));
        for (int k = 0; k < 8; k++) bm[k] = branch_cost(x, y, k);
        for (int s = 0; s < 4; s++) begin
            a = s & 1;
            best_sum = 0;
            bp = 0;
            bu = 0;
            for (int j = 0; j < 4; j++) begin
                p = (j & 1) ? tcmv_pkg::pred_hi(s[1:0]) : tcmv_pkg::pred_lo(s[1:0]);
                sum = path_metric[p] + bm[a + 2 * j];
                if (j == 0 || sum < best_sum) begin
                    best_sum = sum;
                    bp = p;
                    bu = j >> 1;
                end
            end
            nm[s] = best_sum > MMAX ? MMAX : best_sum;
            surv_pred[wr_col][s] = bp[1:0];
            surv_unc[wr_col][s] = bu[0];
        end
        lo = nm[0];
        best = 0;
        for (int s = 1; s < 4; s++) begin
            if (nm[s] < lo) begin
                lo = nm[s];
                best = s;
            end
        end
        for (int s = 0; s < 4; s++) path_metric[s] = nm[s] - lo;
        if (fill < DEPTH - 1) begin
            fill++;
        end else begin
            st = best;
            col = wr_col;
            for (int n = 0; n < DEPTH - 1; n++) begin
                st = surv_pred[col][st];
                col = (col == 0) ? DEPTH - 1 : col - 1;
            end
            expected_symbols.push_back({surv_unc[col][st], st[1]});
        end
        wr_col = (wr_col + 1) % DEPTH;
    endtask

    // A point of the constellation plus noise, so the trellis follows real paths.
    function automatic sample_t noisy_point(int k, int noise);
        longint x, y;
        sample_t r;
        x = coord(tcmv_pkg::pt_i(k[2:0])) + $signed($urandom_range(2 * noise, 0)) - noise;
        y = coord(tcmv_pkg::pt_q(k[2:0])) + $signed($urandom_range(2 * noise, 0)) - noise;
        r.si = x[SW-1:0];
        r.sq = y[SW-1:0];
        return r;
    endfunction

    // Driver: hold the beat until accepted, idle at random between beats.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                sample_t smp;
                smp = pending_samples.pop_front();
                i_sample_i <= smp.si;
                i_sample_q <= smp.sq;
                i_in_valid <= 1'b1;
                decode_sample(smp);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each accepted beat with the oldest predicted symbol.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_symbols.size() == 0) begin
                $error("decoded_symbol: expected none, actual %0d", o_decoded_symbol);
                errors++;
            end else begin
                logic [1:0] exp_sym;
                exp_sym = expected_symbols.pop_front();
                if (o_decoded_symbol !== exp_sym) begin
                    $error("decoded_symbol: expected %0d, actual %0d", exp_sym,
                           o_decoded_symbol);
                    errors++;
                end
            end
        end
        if (!i_rst_n) i_out_ready <= 1'b0;
        else i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        sample_t smp;
        int k;
        decoder_reset();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Directed: field extremes and every point, noiseless.
        smp.si = 12'h800; smp.sq = 12'h800; pending_samples.push_back(smp);
        smp.si = 12'h7FF; smp.sq = 12'h7FF; pending_samples.push_back(smp);
        smp.si = 12'h800; smp.sq = 12'h7FF; pending_samples.push_back(smp);
        smp.si = 12'h7FF; smp.sq = 12'h800; pending_samples.push_back(smp);
        smp.si = 12'h000; smp.sq = 12'h000; pending_samples.push_back(smp);
        smp.si = 12'hFFF; smp.sq = 12'h001; pending_samples.push_back(smp);
        for (int i = 0; i < 16; i++) pending_samples.push_back(noisy_point(i % 8, 0));
        // Random: phases none/idle/stall/both, mostly noisy points, some raw noise.
        for (int ph = 0; ph < 4; ph++) begin
            while (pending_samples.size() > 0 || expected_symbols.size() > 0)
                @(posedge i_clk);
            send_idle_pct = (ph == 1) ? 60 : (ph == 3 ? 28 : 0);
            recv_stall_pct = (ph == 2) ? 60 : (ph == 3 ? 28 : 0);
            for (int i = 0; i < N_RANDOM / 4; i++) begin
                k = $urandom_range(7);
                if ($urandom_range(9) < 2) begin
                    smp.si = SW'($urandom);
                    smp.sq = SW'($urandom);
                    pending_samples.push_back(smp);
                end else begin
                    pending_samples.push_back(noisy_point(k, $urandom_range(3) == 0 ? 900 : 250));
                end
            end
        end
        while (pending_samples.size() > 0 || i_in_valid || expected_symbols.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/tcmv_pkg.sv
rtl/core/tcmv_ram.sv
rtl/core/tcmv_bmu.sv
rtl/core/tcm_8psk_viterbi_decoder_unit.sv
tb/tcm_8psk_viterbi_decoder_unit_tb.sv
